/* src/dmrr_pkg.sv */
`default_nettype none
package dmrr_pkg;

  localparam int SPEED_W   = 9;
  localparam int MAG_W     = 8;
  localparam int TRIM_W    = 9;
  localparam int MS_W      = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 1;

  // Reciprocal scale, exact for 12-bit dividends and step counts up to 15.
  localparam int DIV_SHIFT = 16;
  localparam int MUL_A_W   = 12;
  localparam int MUL_B_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [MS_W-1:0] REVERSAL_HOLD_MS = 12'd2;
  localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_TRIM_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_RIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN_MS = 3'd4;

  typedef struct packed {
    logic [1:0]       pad;
    logic [MS_W-1:0]  hold_ms;
    logic [MAG_W-1:0] duty;
    logic             drive_reverse;
    logic             drive_forward;
  } out_data_t;

endpackage
`default_nettype wire

/* src/dual_motor_reversal_ramp_unit.sv */
`default_nettype none
// The first beat of a run is registered after the input beat passes S_HUP, S_HDN, S_TRIM and S_TGT
// and, for a reversal or a start, the divide states. A new input is taken only in S_IDLE, after
// both motors' writes of the last run have been issued; one shared multiplier and a single
// output register set the pace, and output stalls add to this.
// Reset (rst, synchronous, active high) restores the register defaults and clears both
// applied speeds and the output valid.
module dual_motor_reversal_ramp_unit #(
  parameter int RAMP_STEPS = 5
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [dmrr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [dmrr_pkg::CFG_W-1:0]            cfg_data,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // left_speed [8:0], right_speed [17:9], zero pad [23:18]
  input  wire  [dmrr_pkg::IN_TDATA_W-1:0]       s_tdata,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // drive_forward [0], drive_reverse [1], duty [9:2], hold_ms [21:10], zero pad [23:22]
  output logic [dmrr_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // motor_select [0]
  output logic [dmrr_pkg::OUT_TUSER_W-1:0]      m_tuser,
  output logic                                  m_tlast
);
  import dmrr_pkg::*;

  localparam int CNT_W = $clog2(RAMP_STEPS + 1);
  localparam int RECIP = (2 ** DIV_SHIFT + RAMP_STEPS - 1) / RAMP_STEPS;
  localparam logic [MUL_B_W-1:0] RECIP_V = MUL_B_W'(RECIP);
  localparam logic [MUL_B_W-1:0] STEPS_M1 = MUL_B_W'(RAMP_STEPS - 1);
  localparam logic [CNT_W-1:0] STEPS_V = CNT_W'(RAMP_STEPS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HUP   = 4'd1;
  localparam logic [3:0] S_HDN   = 4'd2;
  localparam logic [3:0] S_TRIM  = 4'd3;
  localparam logic [3:0] S_TGT   = 4'd4;
  localparam logic [3:0] S_DNDIV = 4'd5;
  localparam logic [3:0] S_DNACC = 4'd6;
  localparam logic [3:0] S_DOWN  = 4'd7;
  localparam logic [3:0] S_HOLD  = 4'd8;
  localparam logic [3:0] S_UPDIV = 4'd9;
  localparam logic [3:0] S_UP    = 4'd10;
  localparam logic [3:0] S_FINAL = 4'd11;

  logic [3:0]         state;
  logic               motor;
  logic [TRIM_W-1:0]  trim_left, trim_right;
  logic [MAG_W-1:0]   min_drive;
  logic [MS_W-1:0]    ramp_up_ms, ramp_down_ms;
  logic [MAG_W-1:0]   app_mag [2];
  logic               app_neg [2];
  logic [SPEED_W-1:0] spd_l, spd_r;
  logic [MS_W-1:0]    hold_up, hold_dn;
  logic [MAG_W-1:0]   tgt_mag, step;
  logic               tgt_neg;
  logic [MAG_W:0]     acc;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  prod;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  logic [SPEED_W-1:0] cur_spd, spd_mag;
  logic [MAG_W-1:0]   cur_app_mag, tm_sat, tm, acc8;
  logic               cur_app_neg, is_rev, is_start;
  logic [SPEED_W-1:0] tm_raw;
  logic               out_free, emit, e_neg, e_last;
  logic [MAG_W-1:0]   e_mag;
  logic [MS_W-1:0]    e_hold;
  out_data_t          e_data;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign cur_spd     = motor ? spd_r : spd_l;
  assign spd_mag     = cur_spd[SPEED_W-1] ? SPEED_W'(-cur_spd) : cur_spd;
  assign cur_app_mag = app_mag[motor];
  assign cur_app_neg = app_neg[motor];
  assign acc8        = acc[MAG_W-1:0];

  always_comb begin
    tm_raw = prod[SPEED_W+7:8];
    tm_sat = (tm_raw > SPEED_W'(MAG_MAX)) ? MAG_MAX : tm_raw[MAG_W-1:0];
    tm = (tm_sat != '0 && tm_sat < min_drive) ? min_drive : tm_sat;
    is_rev = (tm != '0) && (cur_app_mag != '0) && (cur_app_neg != cur_spd[SPEED_W-1]);
    is_start = (tm != '0) && (cur_app_mag == '0);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_HUP: begin
        mul_a = ramp_up_ms;
        mul_b = RECIP_V;
      end
      S_HDN: begin
        mul_a = ramp_down_ms;
        mul_b = RECIP_V;
      end
      S_TRIM: begin
        mul_a = MUL_A_W'(spd_mag);
        mul_b = MUL_B_W'(motor ? trim_right : trim_left);
      end
      S_TGT: begin
        mul_a = MUL_A_W'(is_rev ? cur_app_mag : tm);
        mul_b = RECIP_V;
      end
      S_DNDIV: begin
        mul_a = MUL_A_W'(prod[DIV_SHIFT +: MAG_W]);
        mul_b = STEPS_M1;
      end
      S_HOLD: begin
        mul_a = MUL_A_W'(tgt_mag);
        mul_b = RECIP_V;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  end

  always_comb begin
    e_mag  = '0;
    e_neg  = 1'b0;
    e_hold = '0;
    e_last = 1'b0;
    emit   = 1'b0;
    unique case (state)
      S_DOWN: begin
        emit   = out_free;
        e_mag  = (acc8 < min_drive) ? '0 : acc8;
        e_neg  = cur_app_neg;
        e_hold = hold_dn;
      end
      S_HOLD: begin
        emit   = out_free;
        e_hold = REVERSAL_HOLD_MS;
      end
      S_UP: begin
        emit   = out_free;
        e_mag  = (acc8 < min_drive) ? min_drive : acc8;
        e_neg  = tgt_neg;
        e_hold = hold_up;
      end
      S_FINAL: begin
        emit   = out_free;
        e_mag  = tgt_mag;
        e_neg  = tgt_neg;
        e_last = motor;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    e_data.pad           = '0;
    e_data.hold_ms       = e_hold;
    e_data.duty          = e_mag;
    e_data.drive_reverse = (e_mag != '0) && e_neg;
    e_data.drive_forward = (e_mag != '0) && !e_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      m_tdata <= e_data;
      m_tuser <= motor;
      m_tlast <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_left    <= 9'd256;
      trim_right   <= 9'd256;
      min_drive    <= 8'd50;
      ramp_up_ms   <= 12'd100;
      ramp_down_ms <= 12'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIM_LEFT:    trim_left    <= cfg_data[TRIM_W-1:0];
        REG_TRIM_RIGHT:   trim_right   <= cfg_data[TRIM_W-1:0];
        REG_MIN_DRIVE:    min_drive    <= cfg_data[MAG_W-1:0];
        REG_RAMP_UP_MS:   ramp_up_ms   <= cfg_data[MS_W-1:0];
        REG_RAMP_DOWN_MS: ramp_down_ms <= cfg_data[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      motor      <= 1'b0;
      app_mag[0] <= '0;
      app_mag[1] <= '0;
      app_neg[0] <= 1'b0;
      app_neg[1] <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            spd_l <= s_tdata[SPEED_W-1:0];
            spd_r <= s_tdata[2*SPEED_W-1:SPEED_W];
            motor <= 1'b0;
            state <= S_HUP;
          end
        end
        S_HUP: begin
          state <= S_HDN;
        end
        S_HDN: begin
          hold_up <= prod[DIV_SHIFT +: MS_W];
          state   <= S_TRIM;
        end
        S_TRIM: begin
          if (!motor) begin
            hold_dn <= prod[DIV_SHIFT +: MS_W];
          end
          state <= S_TGT;
        end
        S_TGT: begin
          tgt_mag <= tm;
          tgt_neg <= cur_spd[SPEED_W-1];
          if (is_rev) begin
            state <= S_DNDIV;
          end else if (is_start) begin
            state <= S_UPDIV;
          end else begin
            state <= S_FINAL;
          end
        end
        S_DNDIV: begin
          step  <= prod[DIV_SHIFT +: MAG_W];
          state <= S_DNACC;
        end
        S_DNACC: begin
          acc   <= prod[MAG_W:0];
          cnt   <= STEPS_V;
          state <= S_DOWN;
        end
        S_DOWN: begin
          if (emit) begin
            acc <= acc - {1'b0, step};
            cnt <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (emit) begin
            state <= S_UPDIV;
          end
        end
        S_UPDIV: begin
          step  <= prod[DIV_SHIFT +: MAG_W];
          acc   <= {1'b0, prod[DIV_SHIFT +: MAG_W]};
          cnt   <= STEPS_V;
          state <= S_UP;
        end
        S_UP: begin
          if (emit) begin
            acc <= acc + {1'b0, step};
            cnt <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (emit) begin
            app_mag[motor] <= tgt_mag;
            app_neg[motor] <= tgt_neg;
            if (!motor) begin
              motor <= 1'b1;
              state <= S_TRIM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* sim/dmrr_drive_checker.sv */
module dmrr_drive_checker #(
  parameter int RAMP_STEPS = 5
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [dmrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [dmrr_pkg::CFG_W-1:0]          cfg_data,
  input  wire                                s_tvalid,
  input  wire                                s_tready,
  // left_speed [8:0], right_speed [17:9], zero pad [23:18]
  input  wire [dmrr_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  wire                                m_tvalid,
  input  wire                                m_tready,
  // drive_forward [0], drive_reverse [1], duty [9:2], hold_ms [21:10], zero pad [23:22]
  input  wire [dmrr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // motor_select [0]
  input  wire [dmrr_pkg::OUT_TUSER_W-1:0]    m_tuser,
  input  wire                                m_tlast,
  output int                                 mismatches,
  output int                                 outstanding,
  output int                                 commands_seen,
  output int                                 writes_seen,
  output int                                 reversals_seen
);
  import dmrr_pkg::*;

  localparam int MAX_WRITES = 2 * (2 * RAMP_STEPS + 2);

  typedef struct {
    logic             motor;
    logic             fwd;
    logic             rev;
    logic [MAG_W-1:0] duty;
    logic [MS_W-1:0]  hold;
    logic             last;
  } bridge_write_t;

  int trim_l;
  int trim_r;
  int min_drive;
  int ramp_up;
  int ramp_down;
  int applied[2];

  bridge_write_t run_buf[MAX_WRITES];
  int run_len;
  bridge_write_t write_q[$];

  function automatic int trimmed_speed(int s, int trim);
    int mag;
    if (s == 0) return 0;
    mag = (s < 0) ? -s : s;
    mag = (mag * trim) >> 8;
    if (mag > 255) mag = 255;
    if (mag != 0 && mag < min_drive) mag = min_drive;
    return (s < 0) ? -mag : mag;
  endfunction

  task automatic add_write(int motor, int speed, int hold);
    int mag;
    mag = (speed < 0) ? -speed : speed;
    run_buf[run_len].motor = motor[0];
    run_buf[run_len].fwd   = speed > 0;
    run_buf[run_len].rev   = speed < 0;
    run_buf[run_len].duty  = mag[MAG_W-1:0];
    run_buf[run_len].hold  = hold[MS_W-1:0];
    run_buf[run_len].last  = 1'b0;
    run_len++;
  endtask

  task automatic plan_motor(int motor, int target);
    int step;
    int v;
    bit start;
    bit reverse;
    if (target == 0) begin
      applied[motor] = 0;
      add_write(motor, 0, 0);
      return;
    end
    start   = applied[motor] == 0;
    reverse = (applied[motor] > 0 && target < 0) || (applied[motor] < 0 && target > 0);
    if (reverse) begin
      reversals_seen++;
      step = applied[motor] / RAMP_STEPS;
      for (int i = RAMP_STEPS - 1; i >= 0; i--) begin
        v = step * i;
        if (v != 0 && ((v < 0) ? -v : v) < min_drive) v = 0;
        add_write(motor, v, ramp_down / RAMP_STEPS);
      end
      add_write(motor, 0, REVERSAL_HOLD_MS);
      applied[motor] = 0;
    end
    if (start || reverse) begin
      step = target / RAMP_STEPS;
      for (int i = 1; i <= RAMP_STEPS; i++) begin
        v = step * i;
        if (((v < 0) ? -v : v) < min_drive) v = (target > 0) ? min_drive : -min_drive;
        add_write(motor, v, ramp_up / RAMP_STEPS);
      end
    end
    add_write(motor, target, 0);
    applied[motor] = target;
  endtask

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_data_t od;
    bridge_write_t exp_w;
    if (rst) begin
      trim_l         = 256;
      trim_r         = 256;
      min_drive      = 50;
      ramp_up        = 100;
      ramp_down      = 100;
      applied[0]     = 0;
      applied[1]     = 0;
      mismatches     = 0;
      commands_seen  = 0;
      writes_seen    = 0;
      reversals_seen = 0;
      write_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIM_LEFT:    trim_l    = cfg_data[TRIM_W-1:0];
          REG_TRIM_RIGHT:   trim_r    = cfg_data[TRIM_W-1:0];
          REG_MIN_DRIVE:    min_drive = cfg_data[MAG_W-1:0];
          REG_RAMP_UP_MS:   ramp_up   = cfg_data[MS_W-1:0];
          REG_RAMP_DOWN_MS: ramp_down = cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        run_len = 0;
        plan_motor(0, trimmed_speed($signed(s_tdata[SPEED_W-1:0]), trim_l));
        plan_motor(1, trimmed_speed($signed(s_tdata[2*SPEED_W-1:SPEED_W]), trim_r));
        run_buf[run_len-1].last = 1'b1;
        for (int k = 0; k < run_len; k++) write_q.push_back(run_buf[k]);
        commands_seen++;
      end
      if (m_tvalid && m_tready) begin
        od = m_tdata;
        writes_seen++;
        if (write_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected write beat, expected nothing, got tdata %h tuser %h tlast %b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          exp_w = write_q.pop_front();
          check_field("motor_select", exp_w.motor, m_tuser[0]);
          check_field("drive_forward", exp_w.fwd, od.drive_forward);
          check_field("drive_reverse", exp_w.rev, od.drive_reverse);
          check_field("duty", exp_w.duty, od.duty);
          check_field("hold_ms", exp_w.hold, od.hold_ms);
          check_field("last", exp_w.last, m_tlast);
          check_field("tdata pad", 0, od.pad);
        end
      end
    end
    outstanding <= write_q.size();
  end

endmodule

/* sim/tb.sv */
module tb;
  import dmrr_pkg::*;

  localparam int RAMP_STEPS      = 5;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 12;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;

  int mismatches;
  int outstanding;
  int commands_seen;
  int writes_seen;
  int reversals_seen;

  int idle_pct;
  int settings_used;
  int quiet_cycles;
  bit hold_off_req;
  bit cmd_taken;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dual_motor_reversal_ramp_unit #(
    .RAMP_STEPS(RAMP_STEPS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  dmrr_drive_checker #(
    .RAMP_STEPS(RAMP_STEPS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .commands_seen(commands_seen),
    .writes_seen(writes_seen),
    .reversals_seen(reversals_seen)
  );

  always @(posedge clk) begin
    cmd_taken <= s_tvalid && s_tready;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a beat.", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  function automatic int random_speed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return 0;
    if (pick < 30) begin
      case ($urandom_range(2))
        0: return 255;
        1: return -255;
        default: return -256;
      endcase
    end
    return int'($urandom_range(511)) - 256;
  endfunction

  function automatic int random_trim();
    if ($urandom_range(99) < 15) return $urandom_range(511);
    return $urandom_range(320, 192);
  endfunction

  task automatic send(int left, int right);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-2*SPEED_W){1'b0}}, right[SPEED_W-1:0], left[SPEED_W-1:0]};
    do @(negedge clk); while (!cmd_taken);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(int tl, int tr, int md, int ru, int rd);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TRIM_LEFT;
    cfg_data  <= CFG_W'(tl);
    @(negedge clk);
    cfg_index <= REG_TRIM_RIGHT;
    cfg_data  <= CFG_W'(tr);
    @(negedge clk);
    cfg_index <= REG_MIN_DRIVE;
    cfg_data  <= CFG_W'(md);
    @(negedge clk);
    cfg_index <= REG_RAMP_UP_MS;
    cfg_data  <= CFG_W'(ru);
    @(negedge clk);
    cfg_index <= REG_RAMP_DOWN_MS;
    cfg_data  <= CFG_W'(rd);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_TRIM_LEFT;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    idle_pct      = 6;
    hold_off_req  = 1'b0;
    settings_used = 1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Power-on settings: stops, starts, same-direction changes, reversals and deadzone lifts.
    send(0, 0);
    send(100, -100);
    send(150, -150);
    send(-200, 200);
    send(255, -255);
    send(-256, -256);
    send(10, -10);
    send(0, 0);
    send(-1, 1);
    send(40, 0);
    send(-40, 255);

    // Zero and tiny trims make nonzero requests vanish, but a right -256 trims to 1; no deadzone and no ramp time.
    drain();
    write_settings(0, 1, 0, 0, 0);
    send(255, -256);
    send(-256, 255);
    send(128, 0);
    send(0, -1);

    // Largest trims, deadzone and ramp times.
    drain();
    write_settings(511, 511, 255, 4095, 4095);
    send(1, -1);
    send(255, -256);
    send(-128, 127);
    send(-1, 1);
    send(0, 0);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      write_settings(random_trim(), random_trim(), $urandom_range(phase == 3 ? 255 : 80),
                     $urandom_range(4095), $urandom_range(4095));
      idle_pct = (phase == 2) ? 0 : 6;
      if (phase == 1) hold_off_req = 1'b1;
      repeat (40) send(random_speed(), random_speed());
    end
    drain();

    $display("Run covered %0d speed commands and %0d bridge write beats, with %0d motor reversals,",
             commands_seen, writes_seen, reversals_seen);
    $display("under %0d register settings, random gaps on both sides and a %0d-cycle output hold-off.",
             settings_used, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
